### rtl/nwkm_pkg.sv
// Shared types and constants for the newest-wins k-way merge block.
// Used by nwkm_ctrl, nwkm_dpath and newest_wins_k_way_merge.
package nwkm_pkg;

    localparam int NUM_SOURCES_DEF = 16;
    localparam int NUM_LEVELS_DEF  = 8;

    localparam int KEY_W       = 64;
    localparam int TAG_W       = 32;
    localparam int SEQ_W       = 64;
    localparam int SRC_FIELD_W = 4;
    localparam int LVL_FIELD_W = 3;
    localparam int MASK_W      = 16;
    localparam int CNT_FIELD_W = 5;
    localparam int MODE_W      = 2;
    localparam int STATUS_W    = 3;
    localparam int S_TDATA_W   = 168;
    localparam int M_TDATA_W   = 120;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    // register index, taken from paddr[2]
    localparam logic REG_DROP  = 1'b0;
    localparam logic REG_COUNT = 1'b1;

    typedef enum logic [1:0] {
        MODE_LOAD    = 2'd0,
        MODE_EXHAUST = 2'd1,
        MODE_PULL    = 2'd2,
        MODE_RSVD    = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_EMIT      = 3'd0,
        ST_DROP      = 3'd1,
        ST_EXHAUSTED = 3'd2,
        ST_ACK       = 3'd3,
        ST_REFILL    = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        HS_EMPTY = 2'd0,
        HS_VALID = 2'd1,
        HS_DONE  = 2'd2
    } head_status_t;

    typedef enum logic [2:0] {
        FSM_IDLE   = 3'd0,
        FSM_SCAN   = 3'd1,
        FSM_DRAIN  = 3'd2,
        FSM_COMMIT = 3'd3,
        FSM_FINISH = 3'd4
    } fsm_state_t;

    typedef struct packed {
        logic accept;
        logic scan_start;
        logic rd_en;
        logic commit;
        logic finish;
    } nwkm_cmd_t;

    typedef struct packed {
        logic scan_needed;
        logic rd_last;
        logic out_free;
    } nwkm_stat_t;

endpackage

### rtl/nwkm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependencies.
module nwkm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/nwkm_ctrl.sv
// Controller state machine: sequences accept, head scan, commit and result hand-off.
// Depends on nwkm_pkg for the state enum and the command/status structs.
module nwkm_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  nwkm_pkg::nwkm_stat_t   stat,
    output nwkm_pkg::nwkm_cmd_t    cmd
);

    nwkm_pkg::fsm_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= nwkm_pkg::FSM_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            nwkm_pkg::FSM_IDLE: begin
                if (s_tvalid) begin
                    state_next = stat.scan_needed ? nwkm_pkg::FSM_SCAN : nwkm_pkg::FSM_FINISH;
                end
            end
            nwkm_pkg::FSM_SCAN: begin
                if (stat.rd_last) begin
                    state_next = nwkm_pkg::FSM_DRAIN;
                end
            end
            nwkm_pkg::FSM_DRAIN: begin
                state_next = nwkm_pkg::FSM_COMMIT;
            end
            nwkm_pkg::FSM_COMMIT: begin
                state_next = nwkm_pkg::FSM_FINISH;
            end
            nwkm_pkg::FSM_FINISH: begin
                if (stat.out_free) begin
                    state_next = nwkm_pkg::FSM_IDLE;
                end
            end
            default: begin
                state_next = nwkm_pkg::FSM_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready       = 1'b0;
        cmd.accept     = 1'b0;
        cmd.scan_start = 1'b0;
        cmd.rd_en      = 1'b0;
        cmd.commit     = 1'b0;
        cmd.finish     = 1'b0;
        case (state_reg)
            nwkm_pkg::FSM_IDLE: begin
                s_tready       = 1'b1;
                cmd.accept     = s_tvalid;
                cmd.scan_start = s_tvalid & stat.scan_needed;
            end
            nwkm_pkg::FSM_SCAN: begin
                cmd.rd_en = 1'b1;
            end
            nwkm_pkg::FSM_COMMIT: begin
                cmd.commit = 1'b1;
            end
            nwkm_pkg::FSM_FINISH: begin
                cmd.finish = stat.out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

### rtl/nwkm_dpath.sv
// Datapath: head status flags, head entry RAM, running minimum, tie mask and
// the output register. Depends on nwkm_pkg and nwkm_ram.
module nwkm_dpath #(
    parameter int NUM_SOURCES = nwkm_pkg::NUM_SOURCES_DEF,
    parameter int NUM_LEVELS  = nwkm_pkg::NUM_LEVELS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  nwkm_pkg::nwkm_cmd_t                 cmd,
    output nwkm_pkg::nwkm_stat_t                stat,
    input  logic [nwkm_pkg::S_TDATA_W-1:0]      s_tdata,
    input  logic [nwkm_pkg::MODE_W-1:0]         s_tuser,
    input  logic                                m_tready,
    output logic                                m_tvalid,
    output logic [nwkm_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic [nwkm_pkg::STATUS_W-1:0]       m_tuser,
    input  logic                                cfg_drop,
    input  logic [nwkm_pkg::CNT_FIELD_W-1:0]    cfg_count
);

    localparam int SRC_W   = $clog2(NUM_SOURCES);
    localparam int LVL_W   = $clog2(NUM_LEVELS);
    localparam int ENTRY_W = nwkm_pkg::KEY_W + 1 + nwkm_pkg::TAG_W + LVL_W + nwkm_pkg::SEQ_W;
    localparam int PAD_W   = nwkm_pkg::M_TDATA_W - nwkm_pkg::SRC_FIELD_W - nwkm_pkg::KEY_W - 1
                             - nwkm_pkg::TAG_W - nwkm_pkg::MASK_W;

    // input unpack
    nwkm_pkg::mode_t                  in_mode;
    logic [nwkm_pkg::SRC_FIELD_W-1:0] in_src;
    logic [nwkm_pkg::KEY_W-1:0]       in_key;
    logic                             in_tomb;
    logic [nwkm_pkg::TAG_W-1:0]       in_tag;
    logic [nwkm_pkg::LVL_FIELD_W-1:0] in_lvl;
    logic [nwkm_pkg::SEQ_W-1:0]       in_seq;
    logic [LVL_W-1:0]                 in_lvl_sat;
    logic                             src_ok;
    logic [SRC_W-1:0]                 wr_idx;

    assign in_mode = nwkm_pkg::mode_t'(s_tuser);
    assign in_src  = s_tdata[3:0];
    assign in_key  = s_tdata[67:4];
    assign in_tomb = s_tdata[68];
    assign in_tag  = s_tdata[100:69];
    assign in_lvl  = s_tdata[103:101];
    assign in_seq  = s_tdata[167:104];

    assign in_lvl_sat = (32'(in_lvl) > 32'(NUM_LEVELS - 1)) ? LVL_W'(NUM_LEVELS - 1)
                                                            : LVL_W'(in_lvl);
    assign src_ok = (32'(in_src) < 32'(NUM_SOURCES));
    assign wr_idx = SRC_W'(in_src);

    // head status flags and per-head checks
    nwkm_pkg::head_status_t head_st_reg [NUM_SOURCES];
    logic [7:0]             act8;
    logic [7:0]             act_last8;
    logic [NUM_SOURCES-1:0] empty_mask;
    logic [NUM_SOURCES-1:0] valid_mask;
    logic [NUM_SOURCES+nwkm_pkg::MASK_W-1:0] empty_pad;

    assign act8 = (8'(cfg_count) > 8'(NUM_SOURCES)) ? 8'(NUM_SOURCES) : 8'(cfg_count);
    assign act_last8 = act8 - 8'd1;

    always_comb begin
        for (int i = 0; i < NUM_SOURCES; i++) begin
            empty_mask[i] = (8'(i) < act8) && (head_st_reg[i] == nwkm_pkg::HS_EMPTY);
            valid_mask[i] = (8'(i) < act8) && (head_st_reg[i] == nwkm_pkg::HS_VALID);
        end
    end

    assign empty_pad = {{nwkm_pkg::MASK_W{1'b0}}, empty_mask};

    // scan pipeline
    logic [SRC_W-1:0]       rd_idx_reg;
    logic [SRC_W-1:0]       cmp_idx_reg;
    logic                   cmp_valid_reg;
    logic                   have_reg;
    logic [NUM_SOURCES-1:0] tie_reg;
    logic [NUM_SOURCES+nwkm_pkg::MASK_W-1:0] tie_pad;
    logic [ENTRY_W-1:0]     ram_wdata;
    logic [ENTRY_W-1:0]     ram_rdata;

    assign ram_wdata = {in_seq, in_lvl_sat, in_tag, in_tomb, in_key};
    assign tie_pad   = {{nwkm_pkg::MASK_W{1'b0}}, tie_reg};

    nwkm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_SOURCES)
    ) u_head_ram (
        .aclk  (aclk),
        .we    (cmd.accept && (in_mode == nwkm_pkg::MODE_LOAD) && src_ok),
        .waddr (wr_idx),
        .wdata (ram_wdata),
        .re    (cmd.rd_en),
        .raddr (rd_idx_reg),
        .rdata (ram_rdata)
    );

    logic [nwkm_pkg::KEY_W-1:0] d_key;
    logic                       d_tomb;
    logic [nwkm_pkg::TAG_W-1:0] d_tag;
    logic [LVL_W-1:0]           d_lvl;
    logic [nwkm_pkg::SEQ_W-1:0] d_seq;

    assign d_key  = ram_rdata[nwkm_pkg::KEY_W-1:0];
    assign d_tomb = ram_rdata[nwkm_pkg::KEY_W];
    assign d_tag  = ram_rdata[nwkm_pkg::KEY_W+1 +: nwkm_pkg::TAG_W];
    assign d_lvl  = ram_rdata[nwkm_pkg::KEY_W+1+nwkm_pkg::TAG_W +: LVL_W];
    assign d_seq  = ram_rdata[ENTRY_W-1 -: nwkm_pkg::SEQ_W];

    logic [nwkm_pkg::KEY_W-1:0] best_key_reg;
    logic                       best_tomb_reg;
    logic [nwkm_pkg::TAG_W-1:0] best_tag_reg;
    logic [LVL_W-1:0]           best_lvl_reg;
    logic [nwkm_pkg::SEQ_W-1:0] best_seq_reg;
    logic [SRC_W-1:0]           best_src_reg;

    logic                   cmp_live;
    logic                   key_lt;
    logic                   key_eq;
    logic                   newer;
    logic                   take;
    logic [NUM_SOURCES-1:0] cmp_onehot;

    assign cmp_live   = cmp_valid_reg && (head_st_reg[cmp_idx_reg] == nwkm_pkg::HS_VALID);
    assign key_lt     = d_key < best_key_reg;
    assign key_eq     = d_key == best_key_reg;
    assign newer      = (d_lvl < best_lvl_reg) ||
                        ((d_lvl == best_lvl_reg) && (d_seq > best_seq_reg));
    assign take       = !have_reg || key_lt || (key_eq && newer);
    assign cmp_onehot = {{(NUM_SOURCES-1){1'b0}}, 1'b1} << cmp_idx_reg;

    // result staging and output register
    nwkm_pkg::status_t           res_status_reg;
    logic [nwkm_pkg::MASK_W-1:0] res_mask_reg;
    logic                        res_win;
    logic                        m_valid_reg;
    logic [nwkm_pkg::M_TDATA_W-1:0] m_data_reg;
    nwkm_pkg::status_t           m_status_reg;
    logic                        out_free;

    assign res_win  = (res_status_reg == nwkm_pkg::ST_EMIT) ||
                      (res_status_reg == nwkm_pkg::ST_DROP);
    assign out_free = !m_valid_reg || m_tready;

    assign stat.scan_needed = (in_mode == nwkm_pkg::MODE_PULL) && !(|empty_mask) &&
                              (|valid_mask);
    assign stat.rd_last     = (8'(rd_idx_reg) == act_last8);
    assign stat.out_free    = out_free;

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_SOURCES; i++) begin
                head_st_reg[i] <= nwkm_pkg::HS_EMPTY;
            end
            rd_idx_reg    <= '0;
            cmp_valid_reg <= 1'b0;
            have_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            cmp_valid_reg <= cmd.rd_en;
            if (cmd.accept && src_ok) begin
                if (in_mode == nwkm_pkg::MODE_LOAD) begin
                    head_st_reg[wr_idx] <= nwkm_pkg::HS_VALID;
                end else if (in_mode == nwkm_pkg::MODE_EXHAUST) begin
                    head_st_reg[wr_idx] <= nwkm_pkg::HS_DONE;
                end
            end
            if (cmd.commit) begin
                for (int i = 0; i < NUM_SOURCES; i++) begin
                    if (tie_reg[i]) begin
                        head_st_reg[i] <= nwkm_pkg::HS_EMPTY;
                    end
                end
            end
            if (cmd.scan_start) begin
                rd_idx_reg <= '0;
                have_reg   <= 1'b0;
            end else if (cmd.rd_en) begin
                rd_idx_reg <= rd_idx_reg + SRC_W'(1);
            end
            if (cmp_live) begin
                have_reg <= 1'b1;
            end
            if (cmd.finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.rd_en) begin
            cmp_idx_reg <= rd_idx_reg;
        end
        if (cmd.scan_start) begin
            tie_reg <= '0;
        end else if (cmp_live) begin
            if (!have_reg || key_lt) begin
                tie_reg <= cmp_onehot;
            end else if (key_eq) begin
                tie_reg <= tie_reg | cmp_onehot;
            end
        end
        if (cmp_live && take) begin
            best_key_reg  <= d_key;
            best_tomb_reg <= d_tomb;
            best_tag_reg  <= d_tag;
            best_lvl_reg  <= d_lvl;
            best_seq_reg  <= d_seq;
            best_src_reg  <= cmp_idx_reg;
        end
        if (cmd.accept) begin
            res_mask_reg <= '0;
            case (in_mode)
                nwkm_pkg::MODE_PULL: begin
                    if (|empty_mask) begin
                        res_status_reg <= nwkm_pkg::ST_REFILL;
                        res_mask_reg   <= empty_pad[nwkm_pkg::MASK_W-1:0];
                    end else begin
                        // overwritten at commit when a scan runs
                        res_status_reg <= nwkm_pkg::ST_EXHAUSTED;
                    end
                end
                default: begin
                    res_status_reg <= nwkm_pkg::ST_ACK;
                end
            endcase
        end
        if (cmd.commit) begin
            res_status_reg <= (best_tomb_reg && cfg_drop) ? nwkm_pkg::ST_DROP
                                                          : nwkm_pkg::ST_EMIT;
            res_mask_reg   <= tie_pad[nwkm_pkg::MASK_W-1:0];
        end
        if (cmd.finish) begin
            m_status_reg <= res_status_reg;
            if (res_win) begin
                m_data_reg <= {{PAD_W{1'b0}}, res_mask_reg, best_tag_reg, best_tomb_reg,
                               best_key_reg, nwkm_pkg::SRC_FIELD_W'(best_src_reg)};
            end else begin
                m_data_reg <= {{PAD_W{1'b0}}, res_mask_reg,
                               {(nwkm_pkg::M_TDATA_W-PAD_W-nwkm_pkg::MASK_W){1'b0}}};
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_status_reg;

endmodule

### rtl/newest_wins_k_way_merge.sv
// Newest-wins k-way merge: load, exhausted and unused-mode items skip the head scan.
// A pull that finds an empty head or no valid head also skips it; a merging
// pull scans active = min(source_count, NUM_SOURCES) heads, fed by
// the head RAM read port that delivers one stored head per cycle to the compare.
// Reset (aresetn low, synchronous) empties every head, turns tombstone dropping off
// and sets the source count to 1; head entry RAM is not cleared and needs no clearing pass.
module newest_wins_k_way_merge #(
    parameter int NUM_SOURCES = nwkm_pkg::NUM_SOURCES_DEF,
    parameter int NUM_LEVELS  = nwkm_pkg::NUM_LEVELS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // s_tdata: source[3:0], entry_key[67:4], entry_tombstone[68], entry_tag[100:69],
    //          run_level[103:101], run_sequence[167:104]
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [nwkm_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic [nwkm_pkg::MODE_W-1:0]       s_tuser,   // mode[1:0]
    // m_tdata: winner_source[3:0], winner_key[67:4], winner_tombstone[68],
    //          winner_tag[100:69], consumed_mask[116:101], zero[119:117]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [nwkm_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic [nwkm_pkg::STATUS_W-1:0]     m_tuser,   // status[2:0]
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [nwkm_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [nwkm_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [nwkm_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);

    logic                             drop_reg;
    logic [nwkm_pkg::CNT_FIELD_W-1:0] count_reg;
    logic                             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            drop_reg  <= 1'b0;
            count_reg <= nwkm_pkg::CNT_FIELD_W'(1);
        end else if (cfg_wr) begin
            if (paddr[2] == nwkm_pkg::REG_DROP) begin
                drop_reg <= pwdata[0];
            end else begin
                count_reg <= pwdata[nwkm_pkg::CNT_FIELD_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == nwkm_pkg::REG_COUNT)
                  ? nwkm_pkg::APB_DATA_W'(count_reg)
                  : nwkm_pkg::APB_DATA_W'(drop_reg);

    nwkm_pkg::nwkm_cmd_t  cmd;
    nwkm_pkg::nwkm_stat_t stat;

    nwkm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    nwkm_dpath #(
        .NUM_SOURCES (NUM_SOURCES),
        .NUM_LEVELS  (NUM_LEVELS)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_drop  (drop_reg),
        .cfg_count (count_reg)
    );

endmodule
